@@ src/srm_pkg.sv @@
// Shared types and constants for the sliding window rate meter.
// No dependencies; the divider, controller, datapath and top level import this package.
`default_nettype none

package srm_pkg;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_START       = 3'd1,
    CMD_PROCESSED   = 3'd2,
    CMD_SET_OFFSET  = 3'd3,
    CMD_OFFSET_PROC = 3'd4,
    CMD_FINISH      = 3'd5,
    CMD_PEER_SPEED  = 3'd6
  } cmd_t;

  localparam logic [15:0] MIN_GAP_RESET = 16'd900;
  localparam logic [9:0]  MS_PER_S      = 10'd1000;
  localparam int          DIV_STEPS     = 64;

  // APB register map: one 32-bit register, word index in paddr[2]
  localparam int          APB_AW      = 3;
  localparam logic [0:0]  REG_MIN_GAP = 1'b0;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture the input beat
    logic exec;       // apply the command's state update
    logic sample;     // append window sample, read oldest entry
    logic span;       // form time and scaled amount spans
    logic div_start;  // kick the serial divider
    logic emit_rate;  // load computed rate into the output register
    logic emit_peer;  // load peer speed into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic take;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

@@ src/srm_ev_if.sv @@
// Input event channel: valid/ready plus command, timestamp and amount.
// No dependencies.
`default_nettype none

interface srm_ev_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] now_ms;
  logic [63:0] amount;

  modport source (output valid, output command, output now_ms, output amount, input ready);
  modport sink   (input valid, input command, input now_ms, input amount, output ready);
endinterface

`default_nettype wire

@@ src/srm_res_if.sv @@
// Result channel: valid/ready plus rate and its origin flag.
// No dependencies.
`default_nettype none

interface srm_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] rate;
  logic        from_peer;

  modport source (output valid, output rate, output from_peer, input ready);
  modport sink   (input valid, input rate, input from_peer, output ready);
endinterface

`default_nettype wire

@@ src/srm_div.sv @@
// Restoring 64 by 32 bit unsigned divider, one quotient bit per cycle.
// Depends on srm_pkg for the step count.
`default_nettype none

module srm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic [63:0]      quotient,
  output logic             done
);
  import srm_pkg::*;

  localparam int CW = $clog2(DIV_STEPS + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [31:0]   rem;
  logic [31:0]   dvsr;
  logic [32:0]   shifted;
  logic [32:0]   trial;

  assign shifted = {rem, quotient[63]};
  assign trial   = shifted - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[32]) begin
        rem      <= trial[31:0];
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        rem      <= shifted[31:0];
        quotient <= {quotient[62:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ src/srm_ctrl.sv @@
// Sequencing state machine of the rate meter.
// Depends on srm_pkg for the command and status structs.
`default_nettype none

module srm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output srm_pkg::dp_cmd_t        cmd,
  input  wire srm_pkg::dp_status_t status
);
  import srm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SAMPLE,
    S_SPAN,
    S_DSTART,
    S_DWAIT,
    S_EMIT_RATE,
    S_EMIT_PEER
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.latch     = in_valid && in_ready;
    cmd.exec      = (state == S_EXEC);
    cmd.sample    = (state == S_SAMPLE);
    cmd.span      = (state == S_SPAN);
    cmd.div_start = (state == S_DSTART);
    cmd.emit_rate = (state == S_EMIT_RATE) && !status.out_busy;
    cmd.emit_peer = (state == S_EMIT_PEER) && !status.out_busy;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (status.cmd == CMD_TICK && status.take) state_next = S_SAMPLE;
        else if (status.cmd == CMD_PEER_SPEED)     state_next = S_EMIT_PEER;
        else                                       state_next = S_IDLE;
      end
      S_SAMPLE: state_next = S_SPAN;
      S_SPAN:   state_next = S_DSTART;
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT: begin
        if (status.div_done) state_next = S_EMIT_RATE;
      end
      S_EMIT_RATE, S_EMIT_PEER: begin
        if (!status.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ src/srm_datapath.sv @@
// Meter state, sample window memory, span math, divider and output register.
// Depends on srm_pkg and srm_div.
`default_nettype none

module srm_datapath #(
  parameter int WINDOW = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire srm_pkg::dp_cmd_t    cmd,
  output srm_pkg::dp_status_t      status,
  input  wire logic [2:0]          command,
  input  wire logic [31:0]         now_ms,
  input  wire logic [63:0]         amount,
  input  wire logic [15:0]         min_gap_ms,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [63:0]              rate,
  output logic                     from_peer
);
  import srm_pkg::*;

  localparam int IW = $clog2(WINDOW);
  localparam int FW = $clog2(WINDOW + 1);
  localparam int SW = IW + 1;

  // captured beat
  cmd_t        cmd_q;
  logic [31:0] now_q;
  logic [63:0] amt_q;

  // meter state
  logic          measuring;
  logic [31:0]   start_ms;
  logic [31:0]   last_sample_ms;
  logic [FW-1:0] fill;
  logic [IW-1:0] head;
  logic [63:0]   processed_bytes;
  logic [63:0]   resume_offset;

  // window ring buffer
  logic [31:0]   time_mem [WINDOW];
  logic [63:0]   amt_mem  [WINDOW];
  logic [31:0]   rd_time;
  logic [63:0]   rd_amt;

  // sample in flight
  logic          alone_q;
  logic [31:0]   new_t;
  logic [63:0]   new_a;
  logic [IW-1:0] new_slot;
  logic [63:0]   dividend_q;
  logic [31:0]   divisor_q;
  logic          tspan_zero;

  logic [31:0]   elapsed;
  logic [31:0]   since_last;
  logic [63:0]   cur;
  logic          full;
  logic [IW-1:0] head_inc;
  logic [IW-1:0] head1;
  logic [FW-1:0] fill1;
  logic [SW-1:0] slot_sum;
  logic [IW-1:0] wr_slot;
  logic          we;
  logic [IW-1:0] waddr;
  logic [31:0]   wtime;
  logic [63:0]   wamt;
  logic [31:0]   old_t;
  logic [63:0]   old_a;
  logic [31:0]   tspan;
  logic [63:0]   aspan;
  logic [63:0]   quotient;
  logic          div_done;
  logic [63:0]   rate_calc;

  assign elapsed    = now_q - start_ms;
  assign since_last = elapsed - last_sample_ms;
  assign cur        = processed_bytes - resume_offset;

  // full window drops its oldest entry before the append
  assign full     = (fill == FW'(WINDOW));
  assign head_inc = (head == IW'(WINDOW - 1)) ? '0 : head + 1'b1;
  assign head1    = full ? head_inc : head;
  assign fill1    = full ? fill - 1'b1 : fill;
  assign slot_sum = SW'(head1) + SW'(fill1);
  assign wr_slot  = (slot_sum >= SW'(WINDOW)) ? IW'(slot_sum - SW'(WINDOW)) : IW'(slot_sum);

  always_comb begin
    we    = 1'b0;
    waddr = wr_slot;
    wtime = elapsed;
    wamt  = cur;
    if (cmd.exec && cmd_q == CMD_START) begin
      we    = 1'b1;
      waddr = '0;
      wtime = '0;
      wamt  = '0;
    end else if (cmd.sample) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr] <= wtime;
      amt_mem[waddr]  <= wamt;
    end
    if (cmd.sample) begin
      rd_time <= time_mem[head1];
      rd_amt  <= amt_mem[head1];
    end
  end

  // with an empty window before the append, the oldest entry is the new one
  assign old_t = alone_q ? new_t : rd_time;
  assign old_a = alone_q ? new_a : rd_amt;
  assign tspan = new_t - old_t;
  assign aspan = new_a - old_a;

  srm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend_q),
    .divisor  (divisor_q),
    .quotient (quotient),
    .done     (div_done)
  );

  assign rate_calc = tspan_zero ? '0 : quotient;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q <= cmd_t'(command);
      now_q <= now_ms;
      amt_q <= amount;
    end
    if (cmd.sample) begin
      alone_q  <= (fill1 == '0);
      new_t    <= elapsed;
      new_a    <= cur;
      new_slot <= wr_slot;
    end
    if (cmd.span) begin
      dividend_q <= aspan * 64'(MS_PER_S);
      divisor_q  <= tspan;
      tspan_zero <= (tspan == '0);
    end
    if (cmd.emit_rate) begin
      rate      <= rate_calc;
      from_peer <= 1'b0;
    end else if (cmd.emit_peer) begin
      rate      <= amt_q;
      from_peer <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      measuring       <= 1'b0;
      start_ms        <= '0;
      last_sample_ms  <= '0;
      fill            <= '0;
      head            <= '0;
      processed_bytes <= '0;
      resume_offset   <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (cmd_q)
          CMD_START: begin
            start_ms        <= now_q;
            last_sample_ms  <= '0;
            processed_bytes <= resume_offset;
            fill            <= FW'(1);
            head            <= '0;
            measuring       <= 1'b1;
          end
          CMD_PROCESSED:   processed_bytes <= amt_q;
          CMD_SET_OFFSET:  resume_offset   <= amt_q;
          CMD_OFFSET_PROC: processed_bytes <= resume_offset;
          CMD_FINISH: begin
            resume_offset <= '0;
            measuring     <= 1'b0;
          end
          CMD_PEER_SPEED:  measuring <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.sample) begin
        last_sample_ms <= elapsed;
        head           <= head1;
        fill           <= fill1 + 1'b1;
      end
      // zero rate restarts the window from the newest sample
      if (cmd.emit_rate && rate_calc == '0) begin
        fill <= FW'(1);
        head <= new_slot;
      end
      if (cmd.emit_rate || cmd.emit_peer) out_valid <= 1'b1;
      else if (out_ready)                 out_valid <= 1'b0;
    end
  end

  always_comb begin
    status          = '0;
    status.cmd      = cmd_q;
    status.take     = measuring && (since_last >= {16'h0000, min_gap_ms});
    status.div_done = div_done;
    status.out_busy = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

@@ src/sliding_window_rate_meter.sv @@
// Sliding window rate meter top level: APB register, controller, datapath.
// Depends on srm_pkg, srm_ev_if, srm_res_if, srm_ctrl and srm_datapath.
`default_nettype none

// Takes one event beat at a time; ev.ready is high only while the controller
// is idle. A command that gives no result passes through capture and execute;
// a peer speed also waits until the output register is free. A tick that
// takes a sample passes through capture, execute, window append with the
// oldest-entry read, span and x1000 scaling, divider start, the bit-serial
// divider (64 quotient steps, then the done flag) and the output load once
// the output register is free. A finished result sits in the output register,
// and the next event is taken while it waits. The window holds WINDOW samples
// (2..64) in a ring buffer; min_gap_ms lives at APB address 0.
module sliding_window_rate_meter #(
  parameter int WINDOW = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [srm_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  srm_ev_if.sink                          ev,
  srm_res_if.source                       res
);
  import srm_pkg::*;

  logic       [15:0] min_gap_ms;
  dp_cmd_t           cmd;
  dp_status_t        status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap_ms <= MIN_GAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MIN_GAP) begin
      min_gap_ms <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_MIN_GAP) ? {16'h0000, min_gap_ms} : '0;

  srm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ev.valid),
    .in_ready (ev.ready),
    .cmd      (cmd),
    .status   (status)
  );

  srm_datapath #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .command    (ev.command),
    .now_ms     (ev.now_ms),
    .amount     (ev.amount),
    .min_gap_ms (min_gap_ms),
    .out_ready  (res.ready),
    .out_valid  (res.valid),
    .rate       (res.rate),
    .from_peer  (res.from_peer)
  );

endmodule

`default_nettype wire
